// ===== rtl/opt_pkg.sv =====
// ----------------------------------------------------------------------------
// opt_pkg: shared definitions for the ordered process table
// Sizes, request modes, result status codes, the stored entry layout and the
// controller states used by the table.
// ----------------------------------------------------------------------------
package opt_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   // Field widths of a request and a result.
   localparam int MODE_W   = 3;
   localparam int ID_W     = 16;
   localparam int ST_W     = 3;
   localparam int STATUS_W = 2;
   localparam int HEAD_W   = ID_W + 1;

   // Request modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 3'd0,
      MODE_UPDATE = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_QUERY  = 3'd3,
      MODE_HEAD   = 3'd4
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // One stored table entry.
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [ST_W-1:0] st;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_HEAD,
      S_RESP
   } state_type;

endpackage

// ===== rtl/opt_ram.sv =====
// ----------------------------------------------------------------------------
// opt_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module opt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ordered_process_table.sv =====
// ----------------------------------------------------------------------------
// ordered_process_table: insertion-ordered table of process entries
// Entries live in a dual-port memory and are walked one per cycle by a small
// controller: insert, update, remove, membership query and read head.
// ----------------------------------------------------------------------------
// One request at a time is processed. After a request is accepted, the
// controller walks the entry memory where the mode needs it, reads the head
// entry and then loads the result register. Insert, read head, the spare
// modes and any search on an empty table do not walk the table. Update and
// query visit one entry per cycle from the head until the first match or the
// last entry. A remove visits entries up to the match and then moves every
// later entry up one place at one entry per cycle. The next request is
// accepted once the result register is loaded. The single read port of the
// entry memory sets the pace of the walk. A finished result waits in its
// output register while the next request is already being worked on; only
// when that register still holds an untaken result does the controller wait
// for it before loading the next one.
module ordered_process_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [opt_pkg::MODE_W-1:0]          req_mode,
   input  logic [opt_pkg::ID_W-1:0]            req_process_id,
   input  logic [opt_pkg::ST_W-1:0]            req_new_state,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [opt_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic signed [opt_pkg::HEAD_W-1:0]   rsp_head_id
);
   import opt_pkg::*;

   // Control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Request and result working registers.
   mode_type           mode_ff, mode_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [ST_W-1:0]    st_ff, st_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;

   // Output registers.
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic signed [HEAD_W-1:0] rsp_head_ff, rsp_head_in;

   // Memory ports.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;

   // Helper terms.
   logic               req_accept;
   logic               out_free;
   logic               hit;
   logic [CNT_W:0]     idx_p1;
   logic [CNT_W:0]     idx_p2;
   logic [CNT_W:0]     count_x;
   logic               more_p1;
   logic               more_p2;
   mode_type           req_mode_t;
   status_type         miss_status;

   opt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry    = entry_type'(rd_data);
   assign req_mode_t  = mode_type'(req_mode);
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign hit         = (rd_entry.id == id_ff);
   assign idx_p1      = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(1);
   assign idx_p2      = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);
   assign count_x     = (CNT_W + 1)'(count_ff);
   assign more_p1     = (idx_p1 < count_x);
   assign more_p2     = (idx_p2 < count_x);
   // A query that misses still reports success; only found tells the answer.
   assign miss_status = (mode_ff == MODE_QUERY) ? STATUS_OK : STATUS_NOT_FOUND;

   // Next controller state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if ((req_mode_t inside {MODE_UPDATE, MODE_REMOVE, MODE_QUERY}) &&
                   (count_ff != '0)) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = ((mode_ff == MODE_REMOVE) && more_p1) ? S_SHIFT : S_HEAD;
            end else begin
               state_in = more_p1 ? S_SEARCH : S_HEAD;
            end
         end
         S_SHIFT: begin
            state_in = more_p2 ? S_SHIFT : S_HEAD;
         end
         S_HEAD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory accesses and working register updates for each state.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      st_in         = st_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = '{id: id_ff, st: st_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in   = req_mode_t;
               id_in     = req_process_id;
               st_in     = req_new_state;
               status_in = STATUS_OK;
               found_in  = 1'b0;
               idx_in    = '0;
               case (req_mode_t)
                  MODE_INSERT: begin
                     // Append at the tail unless every slot is taken.
                     if (count_ff == CNT_W'(MAX_PROCS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_entry = '{id: req_process_id, st: req_new_state};
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_UPDATE, MODE_REMOVE, MODE_QUERY: begin
                     // Start the walk at the head, or miss at once on an empty table.
                     if (count_ff != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                     end else if (req_mode_t != MODE_QUERY) begin
                        status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (hit) begin
               case (mode_ff)
                  MODE_UPDATE: begin
                     wr_en    = 1'b1;
                     wr_addr  = idx_ff;
                     wr_entry = '{id: id_ff, st: st_ff};
                  end
                  MODE_QUERY: begin
                     found_in = 1'b1;
                  end
                  MODE_REMOVE: begin
                     // Fetch the follower to move up, or drop the tail directly.
                     if (more_p1) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_p1[IDX_W-1:0];
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     found_in = 1'b0;
                  end
               endcase
            end else if (more_p1) begin
               rd_en   = 1'b1;
               rd_addr = idx_p1[IDX_W-1:0];
               idx_in  = idx_p1[IDX_W-1:0];
            end else begin
               status_in = miss_status;
            end
         end

         S_SHIFT: begin
            // Move the fetched entry up one place and fetch the next one, if any.
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_entry = rd_entry;
            idx_in   = idx_p1[IDX_W-1:0];
            if (more_p2) begin
               rd_en   = 1'b1;
               rd_addr = idx_p2[IDX_W-1:0];
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end

         S_HEAD: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end

         S_RESP: begin
            // Load the result once the output register is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               if (count_ff == '0) begin
                  rsp_head_in = '1;
               end else begin
                  rsp_head_in = {1'b0, rd_entry.id};
               end
            end
         end

         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      rsp_valid   = rsp_valid_ff;
      rsp_status  = rsp_status_ff;
      rsp_found   = rsp_found_ff;
      rsp_head_id = rsp_head_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      st_ff         <= st_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_head_ff   <= rsp_head_in;
   end

endmodule
